### hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, character codes, command codes and word types of the text
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;

	localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_COUNT - 1);
	localparam logic [CELL_W-1:0] COPY_LAST = CELL_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [CELL_W-1:0] FILL_FIRST = CELL_W'((ROWS - 1) * COLUMNS);

	localparam logic [15:0] BLANK_WHITE = 16'h0F20;
	localparam logic [7:0]  COLOR_RST   = 8'h0F;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam logic [7:0]  CH_BS       = 8'd8;
	localparam logic [7:0]  CH_TAB      = 8'd9;
	localparam logic [7:0]  CH_NL       = 8'd10;
	localparam logic [COL_W:0] TAB_MASK = ~(COL_W + 1)'(3);

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]       command;
		logic [7:0]       char_code;
		logic [COL_W-1:0] read_col;
		logic [ROW_W-1:0] read_row;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
		logic             scrolled;
		logic [15:0]      cell_value;
	} res_t;

	// linear cell index, row major
	function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return CELL_W'(int'(row) * COLUMNS + int'(col));
	endfunction

endpackage
`default_nettype wire

### hdl/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: cell store, cursor, put-char / clear / read commands.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: present a word on cmd and raise start; it is taken at a
//   rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with the result word; the
//   receiver cannot stall it, so it must take the word in that cycle.
//   Color register: cfg_we/cfg_wdata write it at any rising edge;
//   change it only while the block is idle.
// Sequence (command taken to done)
//   plain character, backspace, newline, tab, unused code: done next cycle
//   read one cell: through the store's read register, then ST_READ
//   scroll: ST_COPY moves the rows up, then ST_BOTTOM blanks the last row,
//     one cell moved per cycle through the single read and write port
//   clear: one cell written per cycle
//   busy stays high for the whole multi-cycle command, so one command at a
//   time; a new command may be taken in the cycle done is high.
// Reset
//   arst_n low clears the cursor and sets the color register to 0x0F. After reset a
//   clearing pass writes 0x0F20 into every cell with busy high; the color
//   register still takes writes meanwhile.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire tcw_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output tcw_pkg::res_t      result,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata
);
	import tcw_pkg::*;

	localparam logic [2:0] ST_INIT   = 3'd0;  // clearing pass after reset
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_FILL   = 3'd2;  // clear command
	localparam logic [2:0] ST_COPY   = 3'd3;  // scroll: move rows up
	localparam logic [2:0] ST_BOTTOM = 3'd4;  // scroll: blank last row
	localparam logic [2:0] ST_READ   = 3'd5;  // wait for read data

	logic [2:0]        state_q;
	logic [CELL_W-1:0] ptr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [7:0]        color_q;
	logic              done_q;
	res_t              res_q;
	logic              rd_ok_q;

	// scroll copy pipeline: read issued in ST_COPY, write in the following cycle
	logic              copy_vld_s1;
	logic [CELL_W-1:0] copy_addr_s1;

	// cell store, synchronous read
	logic [15:0]       mem [CELL_COUNT];
	logic [15:0]       rd_q;
	logic              mem_we;
	logic [CELL_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [CELL_W-1:0] mem_raddr;

	logic accept;
	logic is_bs, is_nl, is_tab, is_glyph;
	logic [COL_W:0]   col_sum;
	logic [ROW_W:0]   row_sum;
	logic             put_scroll;
	logic [COL_W-1:0] put_col;
	logic [ROW_W-1:0] put_row;
	logic             rd_in_range;
	logic [15:0]      color_blank;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign done        = done_q;
	assign result      = res_q;
	assign color_blank = {color_q, CH_SPACE};

	assign is_bs    = (cmd.char_code == CH_BS);
	assign is_nl    = (cmd.char_code == CH_NL);
	assign is_tab   = (cmd.char_code == CH_TAB);
	assign is_glyph = !is_bs && !is_nl && !is_tab;

	assign rd_in_range = (int'(cmd.read_col) < COLUMNS) && (int'(cmd.read_row) < ROWS);

	// next cursor for newline, tab and glyph
	always_comb begin
		row_sum = {1'b0, row_q};
		priority if (is_nl) begin
			col_sum = '0;
			row_sum = {1'b0, row_q} + 1'b1;
		end else if (is_tab) begin
			col_sum = ({1'b0, col_q} + (COL_W + 1)'(4)) & TAB_MASK;
		end else begin
			col_sum = {1'b0, col_q} + 1'b1;
		end
		if (int'(col_sum) >= COLUMNS) begin
			col_sum = '0;
			row_sum = row_sum + 1'b1;
		end
		put_scroll = (int'(row_sum) >= ROWS);
		put_col    = col_sum[COL_W-1:0];
		put_row    = put_scroll ? ROW_W'(ROWS - 1) : row_sum[ROW_W-1:0];
	end

	// write port: a pending scroll copy goes first
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = color_blank;
		priority if (copy_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_s1;
			mem_wdata = rd_q;
		end else if (state_q == ST_INIT) begin
			mem_we    = 1'b1;
			mem_wdata = BLANK_WHITE;
		end else if (state_q == ST_FILL || state_q == ST_BOTTOM) begin
			mem_we    = 1'b1;
		end else if (accept && cmd.command == CMD_PUT) begin
			if (is_bs) begin
				mem_we    = (col_q != '0);
				mem_waddr = cell_addr(row_q, col_q - 1'b1);
				mem_wdata = BLANK_WHITE;
			end else begin
				mem_we    = is_glyph;
				mem_waddr = cell_addr(row_q, col_q);
				mem_wdata = {color_q, cmd.char_code};
			end
		end
	end

	assign mem_raddr = (state_q == ST_COPY) ? ptr_q + CELL_W'(COLUMNS)
	                                        : cell_addr(cmd.read_row, cmd.read_col);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			ptr_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			color_q      <= COLOR_RST;
			done_q       <= 1'b0;
			res_q        <= '0;
			rd_ok_q      <= 1'b0;
			copy_vld_s1  <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			done_q      <= 1'b0;
			copy_vld_s1 <= 1'b0;
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_INIT: begin
					if (ptr_q == CELL_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_q.cursor_col <= col_q;
						res_q.cursor_row <= row_q;
						res_q.scrolled   <= 1'b0;
						res_q.cell_value <= '0;
						unique case (cmd.command)
							CMD_PUT: begin
								if (is_bs) begin
									done_q <= 1'b1;
									if (col_q != '0) begin
										col_q            <= col_q - 1'b1;
										res_q.cursor_col <= col_q - 1'b1;
									end
								end else begin
									col_q            <= put_col;
									row_q            <= put_row;
									res_q.cursor_col <= put_col;
									res_q.cursor_row <= put_row;
									if (put_scroll) begin
										state_q <= ST_COPY;
										ptr_q   <= '0;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							CMD_CLEAR: begin
								state_q <= ST_FILL;
								ptr_q   <= '0;
								col_q   <= '0;
								row_q   <= '0;
							end
							CMD_READ: begin
								state_q <= ST_READ;
								rd_ok_q <= rd_in_range;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (ptr_q == CELL_LAST) begin
						state_q          <= ST_IDLE;
						done_q           <= 1'b1;
						res_q.cursor_col <= '0;
						res_q.cursor_row <= '0;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_COPY: begin
					copy_vld_s1  <= 1'b1;
					copy_addr_s1 <= ptr_q;
					if (ptr_q == COPY_LAST) begin
						state_q <= ST_BOTTOM;
						ptr_q   <= FILL_FIRST;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_BOTTOM: begin
					// first cycle drains the last copy write
					if (!copy_vld_s1) begin
						if (ptr_q == CELL_LAST) begin
							state_q        <= ST_IDLE;
							done_q         <= 1'b1;
							res_q.scrolled <= 1'b1;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				ST_READ: begin
					state_q          <= ST_IDLE;
					done_q           <= 1'b1;
					res_q.cell_value <= rd_ok_q ? rd_q : 16'h0000;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_copy_from_copy: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> $past(state_q) == ST_COPY)
		else $error("copy write without a copy read");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (int'(res_q.cursor_col) < COLUMNS) && (int'(res_q.cursor_row) < ROWS))
		else $error("cursor out of range");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.scrolled) |-> res_q.cursor_row == ROW_W'(ROWS - 1))
		else $error("scroll left cursor off last row");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= CELL_LAST)
		else $error("cell pointer out of range");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> done_q && state_q == ST_IDLE)
		else $error("read did not finish");

endmodule
`default_nettype wire
